[hdl/dpcva_pkg.sv]
// ----------------------------------------------------------------------------
// Display processor command package
// Shared types, constants and the video RAM address map.
// ----------------------------------------------------------------------------
package dpcva_pkg;

    localparam int VRAM_SIZE = 16384;
    localparam int VRAM_AW   = $clog2(VRAM_SIZE);

    localparam logic [7:0] STATUS_CLEAR_MASK = 8'h78;
    localparam logic [5:0] X_LINE_END        = 6'd39;
    localparam logic [7:0] WRITE_LOW         = 8'h20;
    localparam logic [7:0] WRITE_HIGH        = 8'h28;

    // Command codes (high nibble of register 0)
    localparam logic [3:0] CODE_MAIN3    = 4'h0;
    localparam logic [3:0] CODE_AUX3     = 4'h2;
    localparam logic [3:0] CODE_ONE      = 4'h3;
    localparam logic [3:0] CODE_PTR4     = 4'h4;
    localparam logic [3:0] CODE_PTR5     = 4'h5;
    localparam logic [3:0] CODE_PTR6     = 4'h6;
    localparam logic [3:0] CODE_PTR_AUX  = 4'h7;
    localparam logic [3:0] CODE_INDIRECT = 4'h8;
    localparam logic [3:0] PARAM_NONE    = 4'h6;

    // Indirect register selectors
    localparam logic [2:0] IND_TIMING  = 3'd1;
    localparam logic [2:0] IND_MARGIN  = 3'd2;
    localparam logic [2:0] IND_PAGE    = 3'd3;
    localparam logic [2:0] IND_DISPLAY = 3'd4;
    localparam logic [2:0] IND_ROW     = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_RAM,
        ST_WAIT,
        ST_POINTER,
        ST_CLEAR,
        ST_OUT
    } dpcva_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       clear_step;  // write zero at the clear address
        logic       access;      // take the bus word
        logic       decode;      // clear status, run indirect, latch command
        logic       ram_go;      // start RAM access for byte ram_idx
        logic [1:0] ram_idx;
        logic       ram_done;    // store RAM read data into register
        logic       pointer;     // apply pointer flags and increment
    } dpcva_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       clear_last;
        logic       run;         // this write runs a command
        logic [1:0] kind;        // 0 pointer only, 1 three-byte, 2 one-byte
        logic       valid_cmd;   // a transfer command
        logic       rd;
    } dpcva_status_t;

    // Scrambled map of Z/Y/X to a video RAM address
    function automatic logic [VRAM_AW-1:0] map_addr(input logic [4:0] z,
                                                    input logic [4:0] y,
                                                    input logic [5:0] x);
        logic [13:0] a;
        // The top bit of Z falls outside the 14-bit address
        a = {z[3:0], 7'd0, x[2:0]};
        if (y >= 5'd8) begin
            if (x[5]) begin
                a = a | {6'd0, y[2:0], 5'd0} | {9'd0, y[4:3], 3'd0};
            end
            else begin
                a = a | {4'd0, y, 5'd0} | {8'd0, x};
            end
        end
        else begin
            a = a | {6'd0, x[5:3], 5'd0};
        end
        return a[VRAM_AW-1:0];
    endfunction

endpackage

[hdl/dpcva_ctrl.sv]
// ----------------------------------------------------------------------------
// Display processor command controller
// Sequences bus words, RAM clearing and the steps of each command.
// ----------------------------------------------------------------------------
module dpcva_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output dpcva_pkg::dpcva_cmd_t   cmd,
    input  dpcva_pkg::dpcva_status_t stat
);
    import dpcva_pkg::*;

    dpcva_state_t state_reg, state_next;
    logic [1:0]   idx_reg, idx_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Next state and command outputs
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.ram_idx = idx_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.access = 1'b1;
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (!stat.run)
                    state_next = ST_OUT;
                else
                begin
                    cmd.decode = 1'b1;
                    idx_next   = 2'd0;
                    if (!stat.valid_cmd)
                        state_next = ST_OUT;
                    else if (stat.kind == 2'd0)
                        state_next = ST_POINTER;
                    else
                        state_next = ST_RAM;
                end
            end
            ST_RAM:
            begin
                cmd.ram_go = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                cmd.ram_done = stat.rd;
                if (stat.kind == 2'd1 && idx_reg != 2'd2)
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = ST_RAM;
                end
                else
                    state_next = ST_POINTER;
            end
            ST_POINTER:
            begin
                cmd.pointer = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    // No bus word is taken during the clearing pass
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready)
        else $error("input accepted during clearing pass");
    // An accepted word is followed by decoding
    a_access_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_CMD)
        else $error("accepted word not decoded");
    // A RAM access is always followed by its wait step
    a_ram_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RAM |=> state_reg == ST_WAIT)
        else $error("RAM access without wait");
`endif

endmodule

[hdl/dpcva_datapath.sv]
// ----------------------------------------------------------------------------
// Display processor command datapath
// Register file, indirect registers, status byte and video RAM.
// ----------------------------------------------------------------------------
module dpcva_datapath (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dpcva_pkg::dpcva_cmd_t    cmd,
    output dpcva_pkg::dpcva_status_t stat,
    input  logic                     mode,
    input  logic [7:0]               bus_offset,
    input  logic [7:0]               write_data,
    output logic [7:0]               read_data
);
    import dpcva_pkg::*;

    logic [7:0] regs_reg [8];
    logic [7:0] status_reg, timing_reg, margin_reg, page_reg, display_reg, row_reg;
    logic [7:0] rdata_reg;
    logic       run_reg;
    logic [VRAM_AW-1:0] clr_reg;
    logic [7:0] vram [VRAM_SIZE];
    logic [7:0] vram_q_reg;

    // Latched command decode
    logic       aux_reg, rd_reg, inc_reg, valid_reg;
    logic [1:0] kind_reg;

    logic [3:0] code, param;
    logic       d_aux, d_valid;
    logic [1:0] d_kind;
    assign code  = regs_reg[0][7:4];
    assign param = regs_reg[0][3:0];

    // Decode of the command in register 0
    always_comb
    begin
        d_aux   = 1'b0;
        d_kind  = 2'd0;
        d_valid = 1'b0;
        case (code)
            CODE_MAIN3:   begin d_kind = 2'd1; d_valid = (param != PARAM_NONE); end
            CODE_AUX3:    begin d_kind = 2'd1; d_aux = 1'b1; d_valid = 1'b1; end
            CODE_ONE:     begin d_kind = 2'd2; d_aux = param[2]; d_valid = 1'b1; end
            CODE_PTR6:    d_valid = (param != PARAM_NONE);
            CODE_PTR4, CODE_PTR5: d_valid = 1'b1;
            CODE_PTR_AUX: begin d_aux = 1'b1; d_valid = 1'b1; end
            default:      d_valid = 1'b0;
        endcase
    end

    assign stat.run        = run_reg;
    assign stat.kind       = d_kind;
    assign stat.valid_cmd  = d_valid;
    assign stat.rd         = rd_reg;
    assign stat.clear_last = (clr_reg == VRAM_AW'(VRAM_SIZE - 1));

    // Pointer fields
    logic [7:0] ra, rb;
    logic [2:0] pd;
    logic [4:0] py;
    logic [1:0] pb;
    logic [5:0] px;
    logic [VRAM_AW-1:0] ram_addr;
    assign ra = aux_reg ? regs_reg[4] : regs_reg[6];
    assign rb = aux_reg ? regs_reg[5] : regs_reg[7];
    assign pd = ra[7:5];
    assign py = ra[4:0];
    assign pb = {rb[7] | rb[6], 1'b0};
    assign px = rb[5:0];
    assign ram_addr = map_addr({pd, pb + cmd.ram_idx}, py, px);

    // Incremented pointer
    logic [5:0] nx;
    logic [4:0] ny;
    always_comb
    begin
        nx = (px == X_LINE_END) ? 6'd0 : px + 6'd1;
        ny = (kind_reg == 2'd2 && nx == 6'd0) ? py + 5'd1 : py;
    end

    // Video RAM: clearing pass, writes from the registers, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            vram[clr_reg] <= 8'd0;
        else if (cmd.ram_go && !rd_reg)
            vram[ram_addr] <= regs_reg[2'(cmd.ram_idx) + 3'd1];
        vram_q_reg <= vram[ram_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                regs_reg[i] <= 8'd0;
            status_reg  <= 8'd0;
            timing_reg  <= 8'd0;
            margin_reg  <= 8'd0;
            page_reg    <= 8'd0;
            display_reg <= 8'd0;
            row_reg     <= 8'd0;
            run_reg     <= 1'b0;
            clr_reg     <= '0;
            aux_reg     <= 1'b0;
            rd_reg      <= 1'b0;
            inc_reg     <= 1'b0;
            valid_reg   <= 1'b0;
            kind_reg    <= 2'd0;
            rdata_reg   <= 8'd0;
        end
        else
        begin
            if (cmd.clear_step)
                clr_reg <= clr_reg + 1'b1;
            // Bus word
            if (cmd.access)
            begin
                run_reg   <= 1'b0;
                rdata_reg <= 8'd0;
                if (!mode)
                    rdata_reg <= (bus_offset[2:0] == 3'd0) ? status_reg
                                                           : regs_reg[bus_offset[2:0]];
                else if (bus_offset >= WRITE_LOW && bus_offset <= WRITE_HIGH)
                begin
                    regs_reg[bus_offset[2:0]] <= write_data;
                    run_reg <= bus_offset[3];
                end
            end
            // Command decode and indirect moves
            if (cmd.decode)
            begin
                status_reg <= status_reg & ~STATUS_CLEAR_MASK;
                aux_reg    <= d_aux;
                kind_reg   <= d_kind;
                valid_reg  <= d_valid;
                rd_reg     <= param[3];
                inc_reg    <= param[0];
                if (code == CODE_INDIRECT)
                begin
                    case (param[2:0])
                        IND_TIMING:  if (param[3]) regs_reg[1] <= timing_reg;
                                     else timing_reg <= regs_reg[1];
                        IND_MARGIN:  if (param[3]) regs_reg[1] <= margin_reg;
                                     else margin_reg <= regs_reg[1];
                        IND_PAGE:    if (param[3]) regs_reg[1] <= page_reg;
                                     else page_reg <= regs_reg[1];
                        IND_DISPLAY: if (param[3]) regs_reg[1] <= display_reg;
                                     else display_reg <= regs_reg[1];
                        IND_ROW:     if (param[3]) regs_reg[1] <= row_reg;
                                     else row_reg <= regs_reg[1];
                        default: ;
                    endcase
                end
            end
            // RAM read data into the register file
            if (cmd.ram_done)
                regs_reg[2'(cmd.ram_idx) + 3'd1] <= vram_q_reg;
            // Pointer flags and increment
            if (cmd.pointer)
            begin
                if (px == X_LINE_END)
                    status_reg <= status_reg | (aux_reg ? 8'h10 : 8'h20)
                                  | (inc_reg ? 8'h40 : 8'h00);
                if (inc_reg)
                begin
                    if (aux_reg)
                    begin
                        regs_reg[4] <= {pd, ny};
                        regs_reg[5] <= {pb, nx};
                    end
                    else
                    begin
                        regs_reg[6] <= {pd, ny};
                        regs_reg[7] <= {pb, nx};
                    end
                end
            end
        end
    end

    assign read_data = rdata_reg;

`ifndef SYNTHESIS
    // Writes never return data
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.access && mode |=> rdata_reg == 8'd0)
        else $error("write returned data");
    // Pointer updates only follow a decoded transfer command
    a_ptr_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pointer |-> valid_reg)
        else $error("pointer step without transfer command");
    // A RAM read completes only for read commands
    a_done_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ram_done |-> rd_reg && kind_reg != 2'd0)
        else $error("RAM data stored on a non-read command");
`endif

endmodule

[hdl/display_processor_command_vram_access_core.sv]
// ----------------------------------------------------------------------------
// Display processor command and video RAM access core
// Register front end: bus reads and writes, commands on video RAM.
// ----------------------------------------------------------------------------
// Usage: one bus word enters on the s_axis channel; tdata holds the offset
// and write byte, tuser the access kind. Each word gives one result word on
// m_axis holding the read byte (zero for writes).
// Sequence: a read or plain write is accepted and decoded, then its result is
// offered; a pointer command adds a pointer step, while an indirect command
// goes from decode to the result; a one-byte transfer makes one and a
// three-byte transfer three video RAM accesses, each a RAM step and a wait
// step for the registered read, before the pointer step. One word is handled
// at a time; the next can be accepted in the cycle after the result is taken.
// Reset: all registers but the RAM read register clear, then a clearing pass
// writes zero into every video RAM entry, during which no word is accepted.
// Stall: while m_axis_tready is low the result holds and no new word is
// taken.
// ----------------------------------------------------------------------------
module display_processor_command_vram_access_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // bus_offset[7:0], write_data[15:8]
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // read_data[7:0]
);
    import dpcva_pkg::*;

    dpcva_cmd_t    cmd;
    dpcva_status_t stat;

    dpcva_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    dpcva_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .mode       (s_axis_tuser),
        .bus_offset (s_axis_tdata[7:0]),
        .write_data (s_axis_tdata[15:8]),
        .read_data  (m_axis_tdata)
    );

endmodule
